// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/fisq_pkg.sv
package fisq_pkg;

    localparam logic [31:0] MAGIC_GUESS = 32'h5F3759DF;
    localparam logic [31:0] F32_HALF    = 32'h3F000000;
    localparam logic [31:0] F32_1P5     = 32'h3FC00000;
    localparam logic [31:0] F32_DFLT_NAN = 32'hFFC00000;
    localparam logic [31:0] F32_QUIET   = 32'h00400000;
    localparam int OP_STAGES   = 3;
    localparam int STEP_STAGES = 4 * OP_STAGES;

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] lz;
        lz = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) begin
                lz = 5'(27 - i);
            end
        end
        return lz;
    endfunction

endpackage

// File: sv/fisq_fmul.sv
module fisq_fmul import fisq_pkg::*; (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic              spc;
    logic [31:0]       spv;
    logic [23:0]       ma, mb;
    logic [4:0]        lza, lzb;
    logic [7:0]        ea_e, eb_e;
    logic signed [9:0] n_e;

    logic              r_a_sgn, r_a_spc;
    logic [31:0]       r_a_spv;
    logic signed [9:0] r_a_e;
    logic [23:0]       r_a_ma, r_a_mb;

    logic              r_b_sgn, r_b_spc;
    logic [31:0]       r_b_spv;
    logic signed [9:0] r_b_e;
    logic [47:0]       r_b_prod;

    logic [47:0]       m, w;
    logic signed [9:0] ex, shr;
    logic [4:0]        sh;
    logic              lost, g, st, up, ovf;
    logic [23:0]       mant;
    logic [7:0]        expf;
    logic [30:0]       rnd;
    logic [31:0]       n_p;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        sgn    = i_a[31] ^ i_b[31];
        spc    = 1'b1;
        priority if (a_nan) begin
            spv = i_a | F32_QUIET;
        end else if (b_nan) begin
            spv = i_b | F32_QUIET;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spv = F32_DFLT_NAN;
        end else if (a_inf || b_inf) begin
            spv = {sgn, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            spv = {sgn, 31'd0};
        end else begin
            spv = 32'd0;
            spc = 1'b0;
        end
        ma   = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb   = {(i_b[30:23] != 8'd0), i_b[22:0]};
        ea_e = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb_e = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        lza  = lzc28({ma, 4'd0});
        lzb  = lzc28({mb, 4'd0});
        n_e  = $signed({2'b00, ea_e}) - $signed({5'd0, lza})
             + $signed({2'b00, eb_e}) - $signed({5'd0, lzb}) - 10'sd127;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_sgn <= sgn;
            r_a_spc <= spc;
            r_a_spv <= spv;
            r_a_e   <= n_e;
            r_a_ma  <= ma << lza;
            r_a_mb  <= mb << lzb;
        end
        if (i_en[1]) begin
            r_b_sgn  <= r_a_sgn;
            r_b_spc  <= r_a_spc;
            r_b_spv  <= r_a_spv;
            r_b_e    <= r_a_e;
            r_b_prod <= 48'(r_a_ma) * 48'(r_a_mb);
        end
        if (i_en[2]) begin
            o_p <= n_p;
        end
    end

    always_comb begin
        if (r_b_prod[47]) begin
            m  = r_b_prod;
            ex = r_b_e + 10'sd1;
        end else begin
            m  = r_b_prod << 1;
            ex = r_b_e;
        end
        shr  = 10'sd1 - ex;
        if (ex >= 10'sd1) begin
            sh = 5'd0;
        end else if (shr > 10'sd31) begin
            sh = 5'd31;
        end else begin
            sh = shr[4:0];
        end
        w    = m >> sh;
        lost = |(m & ((48'd1 << sh) - 48'd1));
        mant = w[47:24];
        g    = w[23];
        st   = (|w[22:0]) | lost;
        up   = g & (st | mant[0]);
        expf = (ex >= 10'sd1) ? ex[7:0] : 8'd0;
        ovf  = ex >= 10'sd255;
        rnd  = {expf, mant[22:0]} + {30'd0, up};
        priority if (r_b_spc) begin
            n_p = r_b_spv;
        end else if (ovf) begin
            n_p = {r_b_sgn, 8'hFF, 23'd0};
        end else begin
            n_p = {r_b_sgn, rnd};
        end
    end

endmodule

// File: sv/fisq_fsub.sv
module fisq_fsub import fisq_pkg::*; (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_d
);

    logic        a_nan, b_nan, a_inf, b_inf, sbn, a_big, spc;
    logic [31:0] spv;
    logic [7:0]  ea_e, eb_e, e_l, e_s, d;
    logic [23:0] m_l, m_s;
    logic        s_l, s_s;
    logic [26:0] ms27, msa;
    logic [4:0]  sha;

    logic        r_a_spc, r_a_sl, r_a_sub, r_a_zs;
    logic [31:0] r_a_spv;
    logic [7:0]  r_a_el;
    logic [26:0] r_a_ml, r_a_ms;

    logic        r_b_spc, r_b_sl, r_b_zs;
    logic [31:0] r_b_spv;
    logic [7:0]  r_b_el;
    logic [27:0] r_b_sum;
    logic [4:0]  r_b_lz;

    logic [27:0] sum;
    logic [26:0] s27;
    logic [7:0]  lzn, shl, lim;
    logic [8:0]  ex;
    logic        g, st, up, ovf;
    logic [7:0]  expf;
    logic [30:0] rnd;
    logic [31:0] n_d;

    always_comb begin
        a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        sbn   = ~i_b[31];
        spc   = 1'b1;
        priority if (a_nan) begin
            spv = i_a | F32_QUIET;
        end else if (b_nan) begin
            spv = i_b | F32_QUIET;
        end else if (a_inf && b_inf && (i_a[31] == i_b[31])) begin
            spv = F32_DFLT_NAN;
        end else if (a_inf) begin
            spv = i_a;
        end else if (b_inf) begin
            spv = {sbn, 8'hFF, 23'd0};
        end else begin
            spv = 32'd0;
            spc = 1'b0;
        end
        ea_e  = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        eb_e  = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        a_big = i_a[30:0] >= i_b[30:0];
        if (a_big) begin
            e_l = ea_e;
            e_s = eb_e;
            m_l = {(i_a[30:23] != 8'd0), i_a[22:0]};
            m_s = {(i_b[30:23] != 8'd0), i_b[22:0]};
            s_l = i_a[31];
            s_s = sbn;
        end else begin
            e_l = eb_e;
            e_s = ea_e;
            m_l = {(i_b[30:23] != 8'd0), i_b[22:0]};
            m_s = {(i_a[30:23] != 8'd0), i_a[22:0]};
            s_l = sbn;
            s_s = i_a[31];
        end
        d    = e_l - e_s;
        sha  = (d > 8'd31) ? 5'd31 : d[4:0];
        ms27 = {m_s, 3'd0};
        msa  = (ms27 >> sha) | {26'd0, |(ms27 & ((27'd1 << sha) - 27'd1))};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_spc <= spc;
            r_a_spv <= spv;
            r_a_sl  <= s_l;
            r_a_sub <= s_l ^ s_s;
            r_a_zs  <= s_l & s_s;
            r_a_el  <= e_l;
            r_a_ml  <= {m_l, 3'd0};
            r_a_ms  <= msa;
        end
        if (i_en[1]) begin
            r_b_spc <= r_a_spc;
            r_b_spv <= r_a_spv;
            r_b_sl  <= r_a_sl;
            r_b_zs  <= r_a_zs;
            r_b_el  <= r_a_el;
            r_b_sum <= sum;
            r_b_lz  <= lzc28(sum);
        end
        if (i_en[2]) begin
            o_d <= n_d;
        end
    end

    always_comb begin
        if (r_a_sub) begin
            sum = {1'b0, r_a_ml} - {1'b0, r_a_ms};
        end else begin
            sum = {1'b0, r_a_ml} + {1'b0, r_a_ms};
        end
    end

    always_comb begin
        lzn = {3'd0, r_b_lz} - 8'd1;
        lim = r_b_el - 8'd1;
        shl = (lzn > lim) ? lim : lzn;
        if (r_b_sum[27]) begin
            s27 = {r_b_sum[27:2], r_b_sum[1] | r_b_sum[0]};
            ex  = {1'b0, r_b_el} + 9'd1;
        end else begin
            s27 = r_b_sum[26:0] << shl;
            ex  = {1'b0, r_b_el} - {1'b0, shl};
        end
        g    = s27[2];
        st   = |s27[1:0];
        up   = g & (st | s27[3]);
        expf = s27[26] ? ex[7:0] : 8'd0;
        ovf  = ex >= 9'd255;
        rnd  = {expf, s27[25:3]} + {30'd0, up};
        priority if (r_b_spc) begin
            n_d = r_b_spv;
        end else if (r_b_sum == 28'd0) begin
            n_d = {r_b_zs, 31'd0};
        end else if (ovf) begin
            n_d = {r_b_sl, 8'hFF, 23'd0};
        end else begin
            n_d = {r_b_sl, rnd};
        end
    end

endmodule

// File: sv/fisq_step.sv
module fisq_step import fisq_pkg::*; (
    input  logic                   i_clk,
    input  logic [STEP_STAGES-1:0] i_en,
    input  logic [31:0]            i_xhalf,
    input  logic [31:0]            i_y,
    output logic [31:0]            o_xhalf,
    output logic [31:0]            o_y
);

    logic [31:0] r_y  [0:3*OP_STAGES-1];
    logic [31:0] r_xh [0:STEP_STAGES-1];
    logic [31:0] t1, t2, t3;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y[0]  <= i_y;
            r_xh[0] <= i_xhalf;
        end
        for (int k = 1; k < 3 * OP_STAGES; k++) begin
            if (i_en[k]) begin
                r_y[k] <= r_y[k-1];
            end
        end
        for (int k = 1; k < STEP_STAGES; k++) begin
            if (i_en[k]) begin
                r_xh[k] <= r_xh[k-1];
            end
        end
    end

    fisq_fmul u_mul1 (
        .i_clk (i_clk),
        .i_en  (i_en[0 +: OP_STAGES]),
        .i_a   (i_xhalf),
        .i_b   (i_y),
        .o_p   (t1)
    );

    fisq_fmul u_mul2 (
        .i_clk (i_clk),
        .i_en  (i_en[OP_STAGES +: OP_STAGES]),
        .i_a   (t1),
        .i_b   (r_y[OP_STAGES-1]),
        .o_p   (t2)
    );

    fisq_fsub u_sub (
        .i_clk (i_clk),
        .i_en  (i_en[2*OP_STAGES +: OP_STAGES]),
        .i_a   (F32_1P5),
        .i_b   (t2),
        .o_d   (t3)
    );

    fisq_fmul u_mul3 (
        .i_clk (i_clk),
        .i_en  (i_en[3*OP_STAGES +: OP_STAGES]),
        .i_a   (r_y[3*OP_STAGES-1]),
        .i_b   (t3),
        .o_p   (o_y)
    );

    assign o_xhalf = r_xh[STEP_STAGES-1];

endmodule

// File: sv/fast_inverse_sqrt_float32_top.sv
// channel   | valid    | ready    | payload
// ----------+----------+----------+-----------
// request   | i_valid  | o_ready  | i_x_bits
// result    | o_valid  | i_ready  | o_y_bits
//
// One request per cycle while no stall reaches the first stage (o_ready high).
// Each float op is a 3-stage unit; the 24x24 mantissa multiplier sets one stage.
// Reset clears all stage valid bits; payload registers are not reset.
// A stall holds only full stages; empty stages ahead of it keep filling.
module fast_inverse_sqrt_float32_top import fisq_pkg::*; #(
    parameter int NEWTON_STEPS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_y_bits
);

    localparam int NST = OP_STAGES + STEP_STAGES * NEWTON_STEPS;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;
    logic [31:0]    r_g [0:OP_STAGES-1];
    logic [31:0]    w_xh [0:NEWTON_STEPS];
    logic [31:0]    w_y  [0:NEWTON_STEPS];

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_g[0] <= MAGIC_GUESS - {1'b0, i_x_bits[31:1]};
        end
        for (int k = 1; k < OP_STAGES; k++) begin
            if (en[k]) begin
                r_g[k] <= r_g[k-1];
            end
        end
    end

    fisq_fmul u_half (
        .i_clk (i_clk),
        .i_en  (en[0 +: OP_STAGES]),
        .i_a   (F32_HALF),
        .i_b   (i_x_bits),
        .o_p   (w_xh[0])
    );

    assign w_y[0] = r_g[OP_STAGES-1];

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
        fisq_step u_step (
            .i_clk   (i_clk),
            .i_en    (en[OP_STAGES + STEP_STAGES*k +: STEP_STAGES]),
            .i_xhalf (w_xh[k]),
            .i_y     (w_y[k]),
            .o_xhalf (w_xh[k+1]),
            .o_y     (w_y[k+1])
        );
    end

    assign o_ready  = en[0];
    assign o_valid  = r_v[NST-1];
    assign o_y_bits = w_y[NEWTON_STEPS];

endmodule

// File: sv/fisq_checker.sv
`include "assert_macros.svh"

module fisq_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_y_bits
);

    logic out_stall;

    assign out_stall = o_valid && !i_ready;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(o_y_bits), "result moved")
    `ASSERT_NEXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !o_valid, "result right after reset")
    `ASSERT_NOW(a_no_bubble_stall, i_clk, i_rst_n, i_ready, o_ready, "request refused")

endmodule

bind fast_inverse_sqrt_float32_top fisq_assertions u_fisq_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_y_bits (o_y_bits)
);
